// ===== hdl/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants for the obstacle steering block
// Holds the register map, the reset values, the snapshot that passes from
// the scan tracker to the command unit, and the command unit state type.
// ----------------------------------------------------------------------------
package sos_pkg;

  typedef enum logic [2:0] {
    REG_START_ANGLE     = 3'd0,
    REG_ANGLE_STEP      = 3'd1,
    REG_VALID_MIN_RANGE = 3'd2,
    REG_VALID_MAX_RANGE = 3'd3,
    REG_NEAR_THRESHOLD  = 3'd4,
    REG_TURN_OFFSET     = 3'd5,
    REG_SPIN_RATE       = 3'd6,
    REG_BASE_SPEED      = 3'd7
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 19;

  localparam logic signed [18:0] RST_START_ANGLE     = -19'sd102944;
  localparam logic        [15:0] RST_ANGLE_STEP      = 16'd402;
  localparam logic        [15:0] RST_VALID_MIN_RANGE = 16'd5;
  localparam logic        [15:0] RST_VALID_MAX_RANGE = 16'd1434;
  localparam logic        [15:0] RST_NEAR_THRESHOLD  = 16'd64;
  localparam logic        [17:0] RST_TURN_OFFSET     = 18'd102944;
  localparam logic signed [15:0] RST_SPIN_RATE       = 16'sd1638;
  localparam logic        [15:0] RST_BASE_SPEED      = 16'd3277;

  localparam logic signed [19:0] BEARING_MAX  = 20'sd262143;
  localparam logic        [15:0] ONE_METRE    = 16'd256;
  localparam logic        [27:0] INV_8PI_Q32  = 28'd170891319;
  localparam logic        [16:0] TURN_MAX_MAG = 17'd32767;
  localparam logic        [17:0] UNIT_DIVISOR = 18'd8192;
  localparam int unsigned        DIV_STEPS    = 16;

  typedef struct packed {
    logic signed [18:0] start_angle;
    logic        [15:0] angle_step;
    logic        [15:0] valid_min_range;
    logic        [15:0] valid_max_range;
    logic        [15:0] near_threshold;
    logic        [17:0] turn_offset;
    logic signed [15:0] spin_rate;
    logic        [15:0] base_speed;
  } cfg_t;

  typedef struct packed {
    logic        [15:0] near_range;
    logic signed [18:0] near_bearing;
    logic        [15:0] far_range;
    logic signed [18:0] far_bearing;
  } snap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TURN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } cmd_state_t;

endpackage

// ===== hdl/sos_front.sv =====
// ----------------------------------------------------------------------------
// sos_front: scan tracker
// Advances the bearing per sample and tracks the nearest and farthest valid
// ranges. At the last sample of a scan it pushes a snapshot and re-arms.
// ----------------------------------------------------------------------------
module sos_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sos_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_range,
  input  logic                in_last_sample,
  input  logic                q_full,
  output logic                q_push,
  output sos_pkg::snap_t      q_data
);

  logic signed [18:0] bear_r, bear_nxt;
  logic        [15:0] near_range_r, near_range_nxt;
  logic signed [18:0] near_bear_r, near_bear_nxt;
  logic        [15:0] far_range_r, far_range_nxt;
  logic signed [18:0] far_bear_r, far_bear_nxt;
  logic signed [19:0] bear_sum;
  logic               accept;
  logic               upd_near;
  logic               upd_far;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_last_sample;

  assign upd_near = (in_range > cfg.valid_min_range) && (in_range < near_range_r);
  assign upd_far  = (in_range < cfg.valid_max_range) && (in_range > far_range_r);
  assign bear_sum = 20'(bear_r) + $signed({4'd0, cfg.angle_step});

  always_comb begin
    q_data.near_range   = upd_near ? in_range : near_range_r;
    q_data.near_bearing = upd_near ? bear_r : near_bear_r;
    q_data.far_range    = upd_far ? in_range : far_range_r;
    q_data.far_bearing  = upd_far ? bear_r : far_bear_r;

    bear_nxt       = bear_r;
    near_range_nxt = near_range_r;
    near_bear_nxt  = near_bear_r;
    far_range_nxt  = far_range_r;
    far_bear_nxt   = far_bear_r;
    if (accept) begin
      if (in_last_sample) begin
        bear_nxt       = cfg.start_angle;
        near_range_nxt = cfg.valid_max_range;
        near_bear_nxt  = '0;
        far_range_nxt  = '0;
        far_bear_nxt   = '0;
      end else begin
        bear_nxt       = (bear_sum > sos_pkg::BEARING_MAX) ?
                         sos_pkg::BEARING_MAX[18:0] : bear_sum[18:0];
        near_range_nxt = q_data.near_range;
        near_bear_nxt  = q_data.near_bearing;
        far_range_nxt  = q_data.far_range;
        far_bear_nxt   = q_data.far_bearing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bear_r       <= sos_pkg::RST_START_ANGLE;
      near_range_r <= sos_pkg::RST_VALID_MAX_RANGE;
      near_bear_r  <= '0;
      far_range_r  <= '0;
      far_bear_r   <= '0;
    end else begin
      bear_r       <= bear_nxt;
      near_range_r <= near_range_nxt;
      near_bear_r  <= near_bear_nxt;
      far_range_r  <= far_range_nxt;
      far_bear_r   <= far_bear_nxt;
    end
  end

endmodule

// ===== hdl/sos_fifo.sv =====
// ----------------------------------------------------------------------------
// sos_fifo: snapshot queue
// A small first-in first-out store between the scan tracker and the command
// unit, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sos_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sos_pkg::snap_t push_data,
  input  logic           pop,
  output sos_pkg::snap_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sos_pkg::snap_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/sos_back.sv =====
// ----------------------------------------------------------------------------
// sos_back: steering command unit
// Takes one scan snapshot, scales the chosen bearing by one over eight pi, and
// in the cruising case divides the base speed bit by bit.
// ----------------------------------------------------------------------------
module sos_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sos_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  sos_pkg::snap_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_yaw_rate,
  output logic [15:0]        out_speed
);

  localparam int unsigned STEP_W = $clog2(sos_pkg::DIV_STEPS);

  sos_pkg::cmd_state_t state_r, state_nxt;

  logic               cruise_r;
  logic               spin_r;
  logic               neg_r;
  logic [19:0]        mag_r;
  logic [47:0]        prod_r;
  logic [14:0]        mag_q_r;
  logic [17:0]        div_r;
  logic [18:0]        rem_r;
  logic [15:0]        num_r;
  logic [15:0]        quo_r;
  logic [STEP_W-1:0]  step_r;
  logic signed [15:0] turn_r;
  logic [15:0]        speed_r;

  logic               cruise;
  logic signed [19:0] t_val;
  logic [16:0]        q_round;
  logic [14:0]        q_clamp;
  logic [17:0]        div_val;
  logic [29:0]        num_val;
  logic [18:0]        trial;
  logic               fits;

  assign cruise = q_data.near_range > cfg.near_threshold;

  always_comb begin
    if (!cruise) begin
      t_val = 20'(q_data.far_bearing);
    end else if (q_data.near_bearing < 0) begin
      t_val = 20'(q_data.near_bearing) + $signed({2'b00, cfg.turn_offset});
    end else begin
      t_val = 20'(q_data.near_bearing) - $signed({2'b00, cfg.turn_offset});
    end
  end

  assign q_round = {1'b0, prod_r[47:32]} + 17'(prod_r[31]);
  assign q_clamp = (q_round > sos_pkg::TURN_MAX_MAG) ?
                   sos_pkg::TURN_MAX_MAG[14:0] : q_round[14:0];
  assign div_val = sos_pkg::UNIT_DIVISOR + {1'b0, mag_q_r, 2'b00} + {3'b000, mag_q_r};
  assign num_val = {1'b0, cfg.base_speed, 13'd0} + {13'd0, div_val[17:1]};
  assign trial   = {rem_r[17:0], num_r[15]};
  assign fits    = trial >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sos_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = sos_pkg::ST_MUL;
        end
      end
      sos_pkg::ST_MUL:  state_nxt = sos_pkg::ST_TURN;
      sos_pkg::ST_TURN: state_nxt = cruise_r ? sos_pkg::ST_PREP : sos_pkg::ST_DONE;
      sos_pkg::ST_PREP: state_nxt = sos_pkg::ST_DIV;
      sos_pkg::ST_DIV: begin
        if (step_r == STEP_W'(sos_pkg::DIV_STEPS - 1)) begin
          state_nxt = sos_pkg::ST_DONE;
        end
      end
      sos_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_nxt = sos_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sos_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == sos_pkg::ST_IDLE) && !q_empty;
    out_valid = (state_r == sos_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sos_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      sos_pkg::ST_IDLE: begin
        cruise_r <= cruise;
        spin_r   <= !cruise && (q_data.far_range <= sos_pkg::ONE_METRE);
        neg_r    <= t_val < 0;
        mag_r    <= (t_val < 0) ? 20'(-t_val) : 20'(t_val);
      end
      sos_pkg::ST_MUL: begin
        prod_r <= 48'(mag_r) * 48'(sos_pkg::INV_8PI_Q32);
      end
      sos_pkg::ST_TURN: begin
        mag_q_r <= q_clamp;
        speed_r <= '0;
        if (spin_r) begin
          turn_r <= cfg.spin_rate;
        end else if (neg_r) begin
          turn_r <= -$signed({1'b0, q_clamp});
        end else begin
          turn_r <= $signed({1'b0, q_clamp});
        end
      end
      sos_pkg::ST_PREP: begin
        div_r  <= div_val;
        rem_r  <= {5'd0, num_val[29:16]};
        num_r  <= num_val[15:0];
        quo_r  <= '0;
        step_r <= '0;
      end
      sos_pkg::ST_DIV: begin
        rem_r  <= fits ? trial - {1'b0, div_r} : trial;
        num_r  <= {num_r[14:0], 1'b0};
        quo_r  <= {quo_r[14:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(sos_pkg::DIV_STEPS - 1)) begin
          speed_r <= {quo_r[14:0], fits};
        end
      end
      sos_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_yaw_rate = turn_r;
  assign out_speed    = speed_r;

endmodule

// ===== hdl/scan_obstacle_steering.sv =====
// ----------------------------------------------------------------------------
// scan_obstacle_steering: laser scan obstacle steering block
// Tracks nearest and farthest returns over each scan and issues one turn
// rate and speed command per scan.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_range, in_last_sample
//   out      out_valid/out_stall out_yaw_rate, out_speed
//   cfg      cfg_we              cfg_index, cfg_wdata
//
// The tracker takes one word per cycle and stalls only when the snapshot
// queue is full. Each scan end takes the command unit through idle, multiply,
// turn and done, and when cruising also prep and the 16-step speed divider.
// Reset is synchronous and loads the register reset values and re-arms the
// trackers; there is no clearing pass.
// ----------------------------------------------------------------------------
module scan_obstacle_steering #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_range,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              out_yaw_rate,
  output logic [15:0]                     out_speed,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sos_pkg::cfg_t  cfg_r;
  sos_pkg::snap_t push_data;
  sos_pkg::snap_t pop_data;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle     <= sos_pkg::RST_START_ANGLE;
      cfg_r.angle_step      <= sos_pkg::RST_ANGLE_STEP;
      cfg_r.valid_min_range <= sos_pkg::RST_VALID_MIN_RANGE;
      cfg_r.valid_max_range <= sos_pkg::RST_VALID_MAX_RANGE;
      cfg_r.near_threshold  <= sos_pkg::RST_NEAR_THRESHOLD;
      cfg_r.turn_offset     <= sos_pkg::RST_TURN_OFFSET;
      cfg_r.spin_rate       <= sos_pkg::RST_SPIN_RATE;
      cfg_r.base_speed      <= sos_pkg::RST_BASE_SPEED;
    end else if (cfg_we) begin
      unique case (sos_pkg::reg_index_t'(cfg_index))
        sos_pkg::REG_START_ANGLE:     cfg_r.start_angle     <= $signed(cfg_wdata);
        sos_pkg::REG_ANGLE_STEP:      cfg_r.angle_step      <= cfg_wdata[15:0];
        sos_pkg::REG_VALID_MIN_RANGE: cfg_r.valid_min_range <= cfg_wdata[15:0];
        sos_pkg::REG_VALID_MAX_RANGE: cfg_r.valid_max_range <= cfg_wdata[15:0];
        sos_pkg::REG_NEAR_THRESHOLD:  cfg_r.near_threshold  <= cfg_wdata[15:0];
        sos_pkg::REG_TURN_OFFSET:     cfg_r.turn_offset     <= cfg_wdata[17:0];
        sos_pkg::REG_SPIN_RATE:       cfg_r.spin_rate       <= $signed(cfg_wdata[15:0]);
        sos_pkg::REG_BASE_SPEED:      cfg_r.base_speed      <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  sos_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range       (in_range),
    .in_last_sample (in_last_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_data)
  );

  sos_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  sos_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_yaw_rate (out_yaw_rate),
    .out_speed    (out_speed)
  );

endmodule

// ===== bench/sos_checker.sv =====
// ----------------------------------------------------------------------------
// sos_checker: steering command predictor and scoreboard
// Watches the sample, command and register ports of the obstacle steering
// block, keeps its own copy of the registers and the scan trackers, works out
// the command due at each scan end and compares every accepted command word
// with the oldest one still due.
// ----------------------------------------------------------------------------
module sos_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [15:0]                    in_range,
  input  logic                           in_last_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [15:0]             out_yaw_rate,
  input  logic [15:0]                    out_speed,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    waiting
);

  typedef struct {
    logic signed [15:0] yaw_rate;
    logic [15:0]        speed;
  } steer_cmd_t;

  steer_cmd_t         due_cmds[$];
  sos_pkg::cfg_t      regs;
  logic signed [18:0] bearing;
  logic [15:0]        near_rng;
  logic signed [18:0] near_brg;
  logic [15:0]        far_rng;
  logic signed [18:0] far_brg;
  int unsigned        errs = 0;

  function automatic logic signed [15:0] bearing_to_turn(input int t);
    longint unsigned mag;
    longint unsigned q;
    mag = (t < 0) ? longint'(-t) : longint'(t);
    q = (mag * sos_pkg::INV_8PI_Q32 + 64'h8000_0000) >> 32;
    if (q > 32767) q = 32767;
    return (t < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  task automatic rearm_trackers();
    bearing  = regs.start_angle;
    near_rng = regs.valid_max_range;
    near_brg = '0;
    far_rng  = '0;
    far_brg  = '0;
  endtask

  task automatic write_reg(input logic [2:0] idx,
                           input logic [sos_pkg::CFG_DATA_W-1:0] data);
    case (sos_pkg::reg_index_t'(idx))
      sos_pkg::REG_START_ANGLE:     regs.start_angle     = data;
      sos_pkg::REG_ANGLE_STEP:      regs.angle_step      = data[15:0];
      sos_pkg::REG_VALID_MIN_RANGE: regs.valid_min_range = data[15:0];
      sos_pkg::REG_VALID_MAX_RANGE: regs.valid_max_range = data[15:0];
      sos_pkg::REG_NEAR_THRESHOLD:  regs.near_threshold  = data[15:0];
      sos_pkg::REG_TURN_OFFSET:     regs.turn_offset     = data[17:0];
      sos_pkg::REG_SPIN_RATE:       regs.spin_rate       = data[15:0];
      sos_pkg::REG_BASE_SPEED:      regs.base_speed      = data[15:0];
      default: ;
    endcase
  endtask

  task automatic track_sample(input logic [15:0] rng, input logic last);
    logic signed [18:0] b;
    int                 nb;
    int                 t;
    int                 mag;
    longint             d;
    steer_cmd_t         cmd;
    b = bearing;
    if (rng > regs.valid_min_range && rng < near_rng) begin
      near_rng = rng;
      near_brg = b;
    end
    if (rng < regs.valid_max_range && rng > far_rng) begin
      far_rng = rng;
      far_brg = b;
    end
    nb = int'(b) + int'(regs.angle_step);
    if (nb > 262143) nb = 262143;
    bearing = nb[18:0];
    if (last) begin
      if (near_rng > regs.near_threshold) begin
        if (near_brg < 0) t = int'(near_brg) + int'(regs.turn_offset);
        else t = int'(near_brg) - int'(regs.turn_offset);
        cmd.yaw_rate = bearing_to_turn(t);
        mag = (cmd.yaw_rate < 0) ? -int'(cmd.yaw_rate) : int'(cmd.yaw_rate);
        d = 8192 + 5 * mag;
        cmd.speed = 16'((longint'(regs.base_speed) * 8192 + d / 2) / d);
      end else begin
        cmd.speed = '0;
        if (far_rng > sos_pkg::ONE_METRE) cmd.yaw_rate = bearing_to_turn(int'(far_brg));
        else cmd.yaw_rate = regs.spin_rate;
      end
      due_cmds.push_back(cmd);
      rearm_trackers();
    end
  endtask

  task automatic check_command(input logic signed [15:0] turn, input logic [15:0] spd);
    steer_cmd_t cmd;
    if (due_cmds.size() == 0) begin
      $error("command word with none due: yaw_rate %0d, speed %0d", turn, spd);
      errs++;
    end else begin
      cmd = due_cmds.pop_front();
      if (turn !== cmd.yaw_rate) begin
        $error("yaw_rate mismatch: expected %0d, actual %0d", cmd.yaw_rate, turn);
        errs++;
      end
      if (spd !== cmd.speed) begin
        $error("speed mismatch: expected %0d, actual %0d", cmd.speed, spd);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{start_angle: sos_pkg::RST_START_ANGLE,
               angle_step: sos_pkg::RST_ANGLE_STEP,
               valid_min_range: sos_pkg::RST_VALID_MIN_RANGE,
               valid_max_range: sos_pkg::RST_VALID_MAX_RANGE,
               near_threshold: sos_pkg::RST_NEAR_THRESHOLD,
               turn_offset: sos_pkg::RST_TURN_OFFSET,
               spin_rate: sos_pkg::RST_SPIN_RATE,
               base_speed: sos_pkg::RST_BASE_SPEED};
      rearm_trackers();
      due_cmds.delete();
    end else begin
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) track_sample(in_range, in_last_sample);
      if (out_valid && !out_stall) check_command(out_yaw_rate, out_speed);
    end
    fail_count <= errs;
    waiting    <= due_cmds.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the obstacle steering block
// Feeds directed and random laser scans under several register settings and
// idle patterns, holds the command port off for a long stretch once so the
// block backs up, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [15:0]                     in_range = '0;
  logic                            in_last_sample = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [15:0]              out_yaw_rate;
  logic [15:0]                     out_speed;
  logic                            cfg_we = 1'b0;
  logic [2:0]                      cfg_index = sos_pkg::REG_START_ANGLE;
  logic [sos_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  int unsigned                     fail_count;
  int unsigned                     waiting;
  idle_mode_t                      idle_mode = IDLE_NONE;
  int                              holds_asked = 0;
  int                              quiet = 0;
  sos_pkg::cfg_t                   now_cfg;

  always #2 clk = ~clk;

  scan_obstacle_steering dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range(in_range), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_yaw_rate(out_yaw_rate), .out_speed(out_speed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sos_checker steer_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range(in_range), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_yaw_rate(out_yaw_rate), .out_speed(out_speed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .waiting(waiting)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // The command port either serves a requested long hold-off or stalls at
  // random according to the current idle mode.
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_stall <= ($urandom_range(0, 99) < 59);
      end else if (idle_mode == IDLE_BOTH) begin
        out_stall <= ($urandom_range(0, 99) < 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 59;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 17;
    return 1'b0;
  endfunction

  task automatic send_word(input logic [15:0] rng, input logic last);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_range       <= rng;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_range(input sos_pkg::cfg_t c);
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 31);
      2: v = int'(c.valid_min_range) + int'($urandom_range(0, 4)) - 2;
      3: v = int'(c.valid_max_range) + int'($urandom_range(0, 4)) - 2;
      4: v = int'(c.near_threshold) + int'($urandom_range(0, 4)) - 2;
      5: v = $urandom_range(254, 258);
      6: begin
        if (c.valid_min_range < c.valid_max_range)
          v = $urandom_range(c.valid_min_range, c.valid_max_range);
        else
          v = $urandom_range(0, 65535);
      end
      default: v = $urandom_range(0, 1) ? 0 : 65535;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic send_scan(input int len);
    for (int i = 0; i < len; i++) send_word(pick_range(now_cfg), i == len - 1);
  endtask

  // Waits until every command due has come back and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input sos_pkg::cfg_t s);
    sos_pkg::reg_index_t idx;
    idx = idx.first();
    cfg_we <= 1'b1;
    do begin
      cfg_index <= idx;
      case (idx)
        sos_pkg::REG_START_ANGLE:     cfg_wdata <= s.start_angle;
        sos_pkg::REG_ANGLE_STEP:      cfg_wdata <= sos_pkg::CFG_DATA_W'(s.angle_step);
        sos_pkg::REG_VALID_MIN_RANGE: cfg_wdata <= sos_pkg::CFG_DATA_W'(s.valid_min_range);
        sos_pkg::REG_VALID_MAX_RANGE: cfg_wdata <= sos_pkg::CFG_DATA_W'(s.valid_max_range);
        sos_pkg::REG_NEAR_THRESHOLD:  cfg_wdata <= sos_pkg::CFG_DATA_W'(s.near_threshold);
        sos_pkg::REG_TURN_OFFSET:     cfg_wdata <= sos_pkg::CFG_DATA_W'(s.turn_offset);
        sos_pkg::REG_SPIN_RATE:       cfg_wdata <= sos_pkg::CFG_DATA_W'(s.spin_rate);
        default:                      cfg_wdata <= sos_pkg::CFG_DATA_W'(s.base_speed);
      endcase
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    now_cfg = s;
  endtask

  function automatic sos_pkg::cfg_t random_settings();
    sos_pkg::cfg_t s;
    s.start_angle     = 19'($urandom);
    s.angle_step      = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    s.valid_min_range = 16'($urandom_range(0, 200));
    s.valid_max_range = 16'($urandom_range(300, 20000));
    s.near_threshold  = 16'($urandom_range(0, 1500));
    s.turn_offset     = 18'($urandom);
    s.spin_rate       = 16'($urandom);
    s.base_speed      = 16'($urandom);
    return s;
  endfunction

  initial begin
    sos_pkg::cfg_t s;
    int            sent;
    int            len;
    now_cfg = '{start_angle: sos_pkg::RST_START_ANGLE,
                angle_step: sos_pkg::RST_ANGLE_STEP,
                valid_min_range: sos_pkg::RST_VALID_MIN_RANGE,
                valid_max_range: sos_pkg::RST_VALID_MAX_RANGE,
                near_threshold: sos_pkg::RST_NEAR_THRESHOLD,
                turn_offset: sos_pkg::RST_TURN_OFFSET,
                spin_rate: sos_pkg::RST_SPIN_RATE,
                base_speed: sos_pkg::RST_BASE_SPEED};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans under the reset register values: cruising, boxed in
    // toward the farthest return, boxed in with the spin rate, a scan with
    // no valid return, a single-sample scan and the threshold edges.
    send_word(16'd1000, 1'b0);
    send_word(16'd800, 1'b0);
    send_word(16'd300, 1'b1);
    send_word(16'd50, 1'b0);
    send_word(16'd1433, 1'b0);
    send_word(16'd5, 1'b1);
    send_word(16'd40, 1'b0);
    send_word(16'd200, 1'b0);
    send_word(16'd65535, 1'b1);
    send_word(16'd0, 1'b0);
    send_word(16'd5, 1'b0);
    send_word(16'd1434, 1'b0);
    send_word(16'd65535, 1'b1);
    send_word(16'd64, 1'b1);
    send_word(16'd65, 1'b0);
    send_word(16'd256, 1'b0);
    send_word(16'd257, 1'b1);
    // This scan is left open across a register change.
    send_word(16'd500, 1'b0);
    send_word(16'd600, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: s = '{start_angle: -19'sd262144, angle_step: 16'd0, valid_min_range: 16'd0,
                 valid_max_range: 16'd0, near_threshold: 16'd0, turn_offset: 18'd0,
                 spin_rate: -16'sd32768, base_speed: 16'd0};
        1: s = '{start_angle: 19'sd262143, angle_step: 16'hFFFF,
                 valid_min_range: 16'hFFFF, valid_max_range: 16'hFFFF,
                 near_threshold: 16'hFFFF, turn_offset: 18'h3FFFF,
                 spin_rate: 16'sd32767, base_speed: 16'hFFFF};
        2: s = '{start_angle: -19'sd262144, angle_step: 16'hFFFF, valid_min_range: 16'd0,
                 valid_max_range: 16'hFFFF, near_threshold: 16'd0,
                 turn_offset: 18'h3FFFF, spin_rate: -16'sd1, base_speed: 16'hFFFF};
        default: s = random_settings();
      endcase
      load_settings(s);
      if (phase == 0) send_word(16'd700, 1'b1);
      idle_mode = idle_mode_t'(phase % 4);
      if (phase == 4) holds_asked = holds_asked + 1;
      sent = 0;
      while (sent < 38) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        send_scan(len);
        sent += len;
      end
    end

    idle_mode = IDLE_NONE;
    settle();
    if (fail_count == 0 && waiting == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
